/* hw/rtl/temp_volt_power_interpolator_core_assert.svh */
// Assertion macros used by the power interpolator controller
`ifndef TEMP_VOLT_POWER_INTERPOLATOR_CORE_ASSERT_SVH
`define TEMP_VOLT_POWER_INTERPOLATOR_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define TVPI_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("%m: check failed");
`define TVPI_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("%m: check failed");
`else
`define TVPI_ASSERT(lbl, clk, rst, prop)
`define TVPI_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

/* hw/rtl/tvpi_pkg.sv */
// Types, codes and constants of the power interpolator
`timescale 1ns / 1ps
`default_nettype none
package tvpi_pkg;
  localparam int MAX_ROWS_DEF   = 8;
  localparam int MAX_POINTS_DEF = 8;

  localparam logic [1:0] MODE_QUERY = 2'd0;
  localparam logic [1:0] MODE_ROW   = 2'd1;
  localparam logic [1:0] MODE_POINT = 2'd2;

  typedef struct packed {
    logic [1:0]         mode;
    logic [2:0]         row;
    logic [2:0]         column;
    logic signed [15:0] temperature;
    logic [15:0]        voltage;
    logic [31:0]        power_value;
    logic [3:0]         point_count;
  } in_t;

  typedef struct packed {
    logic [31:0] power;
    logic        empty_error;
  } out_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_SCAN_CMP,
    OP_ROW_END,
    OP_PT_START,
    OP_PT_END,
    OP_PT_STORE,
    OP_NEXT_ROW,
    OP_T_START,
    OP_T_STORE,
    OP_SET_ERR,
    OP_OUT_LOAD
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic rows_zero;
    logic scan_stop;
    logic pt_empty;
    logic pt_same;
    logic lerp_done;
    logic sel_hi;
    logic rows_differ;
  } status_t;
endpackage
`default_nettype wire

/* hw/rtl/tvpi_lerp.sv */
// Serial interpolation unit: a + trunc((b - a) * dx / span), one bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module tvpi_lerp (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] a,
  input  logic [31:0] b,
  input  logic [16:0] dx,
  input  logic [16:0] span,
  output logic        done,
  output logic [31:0] result
);
  logic        busy;
  logic [4:0]  cnt;
  logic [31:0] mag;
  logic [31:0] base;
  logic        neg;
  logic [16:0] dx_q;
  logic [16:0] span_q;
  logic [16:0] rem;
  logic [31:0] quo;

  logic [18:0] part;
  logic [18:0] one_span;
  logic [18:0] two_span;
  logic [18:0] rem_full;
  logic [1:0]  digit;
  logic [31:0] quo_next;

  // one radix-2 step of |b-a|*dx/span; digit is 0..2 since dx < span
  always_comb begin
    one_span = {2'b00, span_q};
    two_span = {1'b0, span_q, 1'b0};
    part     = {1'b0, rem, 1'b0} + (mag[31] ? {2'b00, dx_q} : 19'd0);
    if (part >= two_span) begin
      digit    = 2'd2;
      rem_full = part - two_span;
    end else if (part >= one_span) begin
      digit    = 2'd1;
      rem_full = part - one_span;
    end else begin
      digit    = 2'd0;
      rem_full = part;
    end
    quo_next = {quo[30:0], 1'b0} + {30'd0, digit};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'd31;
        neg  <= (b < a);
        mag  <= (b < a) ? (a - b) : (b - a);
        base <= a;
        dx_q   <= dx;
        span_q <= span;
        rem  <= 17'd0;
        quo  <= 32'd0;
      end else if (busy) begin
        mag <= {mag[30:0], 1'b0};
        rem <= rem_full[16:0];
        quo <= quo_next;
        cnt <= cnt - 5'd1;
        if (cnt == 5'd0) begin
          busy   <= 1'b0;
          done   <= 1'b1;
          result <= neg ? (base - quo_next) : (base + quo_next);
        end
      end
    end
  end
endmodule
`default_nettype wire

/* hw/rtl/tvpi_datapath.sv */
// Table storage, breakpoint search registers and output register
`timescale 1ns / 1ps
`default_nettype none
module tvpi_datapath #(
  parameter int MAX_ROWS   = tvpi_pkg::MAX_ROWS_DEF,
  parameter int MAX_POINTS = tvpi_pkg::MAX_POINTS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  tvpi_pkg::in_t   in_data,
  input  logic            cfg_we,
  input  logic [3:0]      cfg_data,
  input  tvpi_pkg::cmd_t  cmd,
  output tvpi_pkg::status_t st,
  output tvpi_pkg::out_t  out_data
);
  import tvpi_pkg::*;

  localparam int RW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int PW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int IW   = (RW > PW) ? RW : PW;
  localparam int NPT  = MAX_ROWS * MAX_POINTS;
  localparam int AW   = (NPT > 1) ? $clog2(NPT) : 1;
  localparam int LW   = $clog2(((MAX_ROWS > MAX_POINTS) ? MAX_ROWS : MAX_POINTS) + 1);
  localparam int PCW  = $clog2(MAX_POINTS + 1);

  // configuration
  logic [3:0]    row_count;
  logic [LW-1:0] n_rows;

  // storage
  logic signed [15:0] temp_mem [MAX_ROWS];
  logic [47:0]        pt_mem   [NPT];
  logic [PCW-1:0]     pcount   [MAX_ROWS];
  logic signed [15:0] temp_rd;
  logic [47:0]        pt_rd;

  // query operands and search state
  logic signed [15:0] t_q;
  logic [15:0]        v_q;
  logic               scan_pt;
  logic [IW-1:0]      idx;
  logic [LW-1:0]      limit;
  logic [IW-1:0]      lo_idx, hi_idx;
  logic               lo_ok, hi_ok;
  logic signed [16:0] key_lo, key_hi;
  logic [31:0]        pay_lo, pay_hi;
  logic [RW-1:0]      row_lo, row_hi;
  logic signed [16:0] tkey_lo, tkey_hi;
  logic               sel_hi;
  logic [31:0]        rv0, rv1, res_val;
  logic               err;
  out_t               out_q;

  logic [RW-1:0]      row_sel;
  logic               row_ok, col_ok;
  logic [RW-1:0]      wr_row;
  logic [AW-1:0]      wr_addr, rd_addr;
  logic [PCW-1:0]     cnt_clamp;
  logic signed [16:0] cur_key, target;
  logic               is_eq, is_gt;
  logic [LW-1:0]      idx_ext_next;
  logic [IW-1:0]      r_lo_idx, r_hi_idx;
  logic signed [16:0] r_key_lo, r_key_hi;
  logic [31:0]        r_pay_lo, r_pay_hi;
  logic               lerp_start, lerp_done;
  logic [31:0]        lerp_a, lerp_b, lerp_res;
  logic [16:0]        lerp_dx, lerp_span;
  logic               accept_query;

  assign n_rows = (int'(row_count) > MAX_ROWS) ? LW'(MAX_ROWS) : LW'(row_count);

  // write decode
  assign row_ok    = int'(in_data.row) < MAX_ROWS;
  assign col_ok    = int'(in_data.column) < MAX_POINTS;
  assign wr_row    = RW'(in_data.row);
  assign wr_addr   = AW'(int'(in_data.row) * MAX_POINTS + int'(in_data.column));
  assign cnt_clamp = (int'(in_data.point_count) > MAX_POINTS) ? PCW'(MAX_POINTS)
                                                              : PCW'(in_data.point_count);
  assign accept_query = (cmd.op == OP_ACCEPT) && (in_data.mode == MODE_QUERY);

  // read decode
  assign row_sel = sel_hi ? row_hi : row_lo;
  assign rd_addr = AW'(int'(row_sel) * MAX_POINTS + int'(idx[PW-1:0]));

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= 4'd0;
    end else if (cfg_we) begin
      row_count <= cfg_data;
    end
  end

  // row temperature memory
  always_ff @(posedge clk) begin
    if (cmd.op == OP_ACCEPT && in_data.mode == MODE_ROW && row_ok) begin
      temp_mem[wr_row] <= in_data.temperature;
    end
    temp_rd <= temp_mem[idx[RW-1:0]];
  end

  // point memory: voltage over power
  always_ff @(posedge clk) begin
    if (cmd.op == OP_ACCEPT && in_data.mode == MODE_POINT && row_ok && col_ok) begin
      pt_mem[wr_addr] <= {in_data.voltage, in_data.power_value};
    end
    pt_rd <= pt_mem[rd_addr];
  end

  // point counts, cleared at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_ROWS; i++) begin
        pcount[i] <= '0;
      end
    end else if (cmd.op == OP_ACCEPT && in_data.mode == MODE_ROW && row_ok) begin
      pcount[wr_row] <= cnt_clamp;
    end
  end

  // scan compare
  always_comb begin
    cur_key      = scan_pt ? $signed({1'b0, pt_rd[47:32]}) : {temp_rd[15], temp_rd};
    target       = scan_pt ? $signed({1'b0, v_q}) : {t_q[15], t_q};
    is_eq        = (cur_key == target);
    is_gt        = (cur_key > target);
    idx_ext_next = LW'(idx) + LW'(1);
  end

  // fill in a missing neighbor from the other side
  always_comb begin
    r_lo_idx = lo_ok ? lo_idx : hi_idx;
    r_hi_idx = hi_ok ? hi_idx : lo_idx;
    r_key_lo = lo_ok ? key_lo : key_hi;
    r_key_hi = hi_ok ? key_hi : key_lo;
    r_pay_lo = lo_ok ? pay_lo : pay_hi;
    r_pay_hi = hi_ok ? pay_hi : pay_lo;
  end

  // interpolation operands
  always_comb begin
    if (cmd.op == OP_T_START) begin
      lerp_start = 1'b1;
      lerp_a     = rv0;
      lerp_b     = rv1;
      lerp_dx    = 17'({t_q[15], t_q} - tkey_lo);
      lerp_span  = 17'(tkey_hi - tkey_lo);
    end else begin
      lerp_start = (cmd.op == OP_PT_END) && (r_lo_idx != r_hi_idx);
      lerp_a     = r_pay_lo;
      lerp_b     = r_pay_hi;
      lerp_dx    = 17'($signed({1'b0, v_q}) - r_key_lo);
      lerp_span  = 17'(r_key_hi - r_key_lo);
    end
  end

  tvpi_lerp u_lerp (
    .clk    (clk),
    .rst    (rst),
    .start  (lerp_start),
    .a      (lerp_a),
    .b      (lerp_b),
    .dx     (lerp_dx),
    .span   (lerp_span),
    .done   (lerp_done),
    .result (lerp_res)
  );

  // search and result registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_ACCEPT: begin
        if (accept_query) begin
          t_q     <= in_data.temperature;
          v_q     <= in_data.voltage;
          err     <= (n_rows == '0);
          scan_pt <= 1'b0;
          idx     <= '0;
          lo_ok   <= 1'b0;
          hi_ok   <= 1'b0;
          limit   <= n_rows;
          sel_hi  <= 1'b0;
        end
      end
      OP_SCAN_CMP: begin
        if (is_eq) begin
          lo_idx <= idx;
          hi_idx <= idx;
          lo_ok  <= 1'b1;
          hi_ok  <= 1'b1;
          key_lo <= cur_key;
          key_hi <= cur_key;
          pay_lo <= pt_rd[31:0];
          pay_hi <= pt_rd[31:0];
        end else if (is_gt) begin
          hi_idx <= idx;
          hi_ok  <= 1'b1;
          key_hi <= cur_key;
          pay_hi <= pt_rd[31:0];
        end else begin
          lo_idx <= idx;
          lo_ok  <= 1'b1;
          key_lo <= cur_key;
          pay_lo <= pt_rd[31:0];
          idx    <= idx + IW'(1);
        end
      end
      OP_ROW_END: begin
        row_lo  <= r_lo_idx[RW-1:0];
        row_hi  <= r_hi_idx[RW-1:0];
        tkey_lo <= r_key_lo;
        tkey_hi <= r_key_hi;
      end
      OP_PT_START: begin
        scan_pt <= 1'b1;
        idx     <= '0;
        lo_ok   <= 1'b0;
        hi_ok   <= 1'b0;
        limit   <= LW'(pcount[row_sel]);
      end
      OP_PT_END: begin
        if (r_lo_idx == r_hi_idx) begin
          if (sel_hi) begin
            rv1 <= r_pay_lo;
          end else begin
            rv0 <= r_pay_lo;
          end
        end
      end
      OP_PT_STORE: begin
        if (sel_hi) begin
          rv1 <= lerp_res;
        end else begin
          rv0 <= lerp_res;
        end
      end
      OP_NEXT_ROW: begin
        sel_hi <= 1'b1;
      end
      OP_T_STORE: begin
        res_val <= lerp_res;
      end
      OP_SET_ERR: begin
        err <= 1'b1;
      end
      OP_OUT_LOAD: begin
        out_q.empty_error <= err;
        out_q.power       <= err ? 32'd0 : ((row_lo != row_hi) ? res_val : rv0);
      end
      default: begin
      end
    endcase
  end

  // status to the controller
  always_comb begin
    st.rows_zero   = (n_rows == '0);
    st.scan_stop   = is_eq || is_gt || (idx_ext_next == limit);
    st.pt_empty    = (pcount[row_sel] == '0);
    st.pt_same     = (r_lo_idx == r_hi_idx);
    st.lerp_done   = lerp_done;
    st.sel_hi      = sel_hi;
    st.rows_differ = (row_lo != row_hi);
  end

  assign out_data = out_q;
endmodule
`default_nettype wire

/* hw/rtl/tvpi_ctrl.sv */
// Query sequencer: row search, point search per row, interpolations, result handoff
`timescale 1ns / 1ps
`default_nettype none
`include "temp_volt_power_interpolator_core_assert.svh"
module tvpi_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [1:0]        in_mode,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  tvpi_pkg::status_t st,
  output tvpi_pkg::cmd_t    cmd
);
  import tvpi_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ROW_RD,
    S_ROW_CMP,
    S_ROW_END,
    S_PT_SEL,
    S_PT_RD,
    S_PT_CMP,
    S_PT_END,
    S_PT_WAIT,
    S_ROW_NEXT,
    S_T_START,
    S_T_WAIT,
    S_FINISH
  } state_t;

  state_t state, state_next;
  logic   load_out;

  assign in_ready = (state == S_IDLE);

  // next state and datapath command
  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    load_out   = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op = OP_ACCEPT;
          if (in_mode == MODE_QUERY) begin
            state_next = st.rows_zero ? S_FINISH : S_ROW_RD;
          end
        end
      end
      S_ROW_RD: state_next = S_ROW_CMP;
      S_ROW_CMP: begin
        cmd.op = OP_SCAN_CMP;
        state_next = st.scan_stop ? S_ROW_END : S_ROW_RD;
      end
      S_ROW_END: begin
        cmd.op     = OP_ROW_END;
        state_next = S_PT_SEL;
      end
      S_PT_SEL: begin
        if (st.pt_empty) begin
          cmd.op     = OP_SET_ERR;
          state_next = S_FINISH;
        end else begin
          cmd.op     = OP_PT_START;
          state_next = S_PT_RD;
        end
      end
      S_PT_RD: state_next = S_PT_CMP;
      S_PT_CMP: begin
        cmd.op = OP_SCAN_CMP;
        state_next = st.scan_stop ? S_PT_END : S_PT_RD;
      end
      S_PT_END: begin
        cmd.op     = OP_PT_END;
        state_next = st.pt_same ? S_ROW_NEXT : S_PT_WAIT;
      end
      S_PT_WAIT: begin
        if (st.lerp_done) begin
          cmd.op     = OP_PT_STORE;
          state_next = S_ROW_NEXT;
        end
      end
      S_ROW_NEXT: begin
        if (st.rows_differ && !st.sel_hi) begin
          cmd.op     = OP_NEXT_ROW;
          state_next = S_PT_SEL;
        end else if (st.rows_differ) begin
          state_next = S_T_START;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_T_START: begin
        cmd.op     = OP_T_START;
        state_next = S_T_WAIT;
      end
      S_T_WAIT: begin
        if (st.lerp_done) begin
          cmd.op     = OP_T_STORE;
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!out_valid || out_ready) begin
          cmd.op     = OP_OUT_LOAD;
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `TVPI_ASSERT_ALWAYS(a_reset_idle, clk, rst |=> (state == S_IDLE && !out_valid))
  `TVPI_ASSERT(a_done_in_wait, clk, rst, st.lerp_done |-> (state == S_PT_WAIT || state == S_T_WAIT))
  `TVPI_ASSERT(a_result_from_finish, clk, rst, $rose(out_valid) |-> $past(state == S_FINISH))
endmodule
`default_nettype wire

/* hw/rtl/temp_volt_power_interpolator_core.sv */
// Top level of the temperature and voltage power table interpolator
`timescale 1ns / 1ps
`default_nettype none
// Power table interpolator. Mode 1 and mode 2 requests load the table; mode 3 is dropped.
// A query (mode 0) returns one result: it scans the row temperatures, then scans the voltage
// points of the lower bracketing row and, if the voltage falls between points, runs the serial
// interpolation unit (one quotient bit per cycle); the upper row repeats this when the
// temperature falls between rows, followed by one more interpolation pass over temperature.
// The search length and the shared interpolation unit set how long a query takes; one
// request is worked at a time.
// Table memories need no clearing pass after reset; only the point counts and the row count reset to zero.
// The result register holds a finished result while the next request is taken.
module temp_volt_power_interpolator_core #(
  parameter int MAX_ROWS   = tvpi_pkg::MAX_ROWS_DEF,
  parameter int MAX_POINTS = tvpi_pkg::MAX_POINTS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  tvpi_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output tvpi_pkg::out_t out_data,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [3:0]     cfg_data
);
  import tvpi_pkg::*;

  cmd_t    cmd;
  status_t st;

  assign cfg_ready = 1'b1;

  tvpi_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_mode   (in_data.mode),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .cmd       (cmd)
  );

  tvpi_datapath #(
    .MAX_ROWS   (MAX_ROWS),
    .MAX_POINTS (MAX_POINTS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .in_data  (in_data),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .st       (st),
    .out_data (out_data)
  );
endmodule
`default_nettype wire
